@@ src/scra_pkg.sv @@
// ----------------------------------------------------------------------------
// scra_pkg
// shared constants, slot codes and control structs of the run allocator
// ----------------------------------------------------------------------------
package scra_pkg;

  localparam int unsigned SlotW      = 12;
  localparam int unsigned CntW       = 13;
  localparam int unsigned TotalSlots = 4096;
  localparam int unsigned RowSlots   = 1024;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TotalSlots - 1);
  localparam logic [SlotW-1:0] RowMask  = SlotW'(RowSlots - 1);

  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_MAPPED = 2'd1,
    SLOT_GUARD  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SlotW-1:0] addr;
    logic [1:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [SlotW-1:0] first_slot;
    logic [CntW-1:0]  slots_cleared;
  } result_t;

endpackage

@@ src/scra_slot_mem.sv @@
// ----------------------------------------------------------------------------
// scra_slot_mem
// slot state memory, one write and one read per cycle, registered read data
// ----------------------------------------------------------------------------
module scra_slot_mem (
  input  logic               clk_i,
  input  scra_pkg::mem_req_t req_i,
  output logic [1:0]         rdata_o
);

  logic [1:0] mem_q [scra_pkg::TotalSlots];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/scra_ctrl.sv @@
// ----------------------------------------------------------------------------
// scra_ctrl
// sequencer: clearing sweep, slot scan, run write-back and result hand-off
// ----------------------------------------------------------------------------
module scra_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic                         cmd_i,
  input  logic [scra_pkg::SlotW-1:0]   run_length_i,
  input  logic [scra_pkg::SlotW-1:0]   start_slot_i,
  output scra_pkg::mem_req_t           mem_req_o,
  input  logic [1:0]                   mem_rdata_i,
  output scra_pkg::result_t            res_o,
  input  logic                         res_take_i
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int unsigned SW = scra_pkg::SlotW;
  localparam int unsigned CW = scra_pkg::CntW;

  logic [2:0]    state_q, state_d;
  logic          cmd_q, cmd_d;
  logic          pass_q, pass_d;
  logic          issue_q, issue_d;
  logic          chk_vld_q, chk_vld_d;
  logic [SW-1:0] addr_q, addr_d;
  logic [SW-1:0] chk_addr_q, chk_addr_d;
  logic [SW-1:0] end_q, end_d;
  logic [SW-1:0] waddr_q, waddr_d;
  logic [SW-1:0] wend_q, wend_d;
  logic [SW-1:0] cursor_q, cursor_d;
  logic [SW-1:0] len_q, len_d;
  logic [SW-1:0] start_q, start_d;
  logic [CW-1:0] need_q, need_d;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] run_n;
  scra_pkg::result_t res_q, res_d;

  assign run_n = (mem_rdata_i == scra_pkg::SLOT_FREE) ? run_q + CW'(1) : '0;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    pass_d     = pass_q;
    issue_d    = issue_q;
    chk_vld_d  = 1'b0;
    addr_d     = addr_q;
    chk_addr_d = chk_addr_q;
    end_d      = end_q;
    waddr_d    = waddr_q;
    wend_d     = wend_q;
    cursor_d   = cursor_q;
    len_d      = len_q;
    start_d    = start_q;
    need_d     = need_q;
    run_d      = run_q;
    res_d      = res_q;
    mem_req_o  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = waddr_q;
        mem_req_o.wdata = scra_pkg::SLOT_FREE;
        waddr_d         = waddr_q + SW'(1);
        if (waddr_q == scra_pkg::LastSlot) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_d   = cmd_i;
          len_d   = run_length_i;
          start_d = start_slot_i;
          need_d  = {1'b0, run_length_i} + CW'(1);
          run_d   = '0;
          res_d   = '0;
          issue_d = 1'b1;
          end_d   = scra_pkg::LastSlot;
          pass_d  = 1'b0;
          state_d = ST_SCAN;
          if (cmd_i == scra_pkg::CMD_FREE) begin
            addr_d = start_slot_i;
          end else if (run_length_i == '0) begin
            res_d.status = scra_pkg::STATUS_NO_SPACE;
            state_d      = ST_DONE;
          end else if (cursor_q == scra_pkg::LastSlot) begin
            addr_d = '0;
            end_d  = cursor_q | scra_pkg::RowMask;
            pass_d = 1'b1;
          end else begin
            addr_d = cursor_q + SW'(1);
          end
        end
      end

      ST_SCAN: begin
        if (issue_q) begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = addr_q;
          chk_addr_d     = addr_q;
          chk_vld_d      = 1'b1;
          if (addr_q == end_q) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + SW'(1);
          end
        end
        if (chk_vld_q) begin
          if (cmd_q == scra_pkg::CMD_FREE) begin
            if (mem_rdata_i == scra_pkg::SLOT_GUARD) begin
              waddr_d             = start_q;
              wend_d              = chk_addr_q;
              res_d.status        = scra_pkg::STATUS_OK;
              res_d.slots_cleared = {1'b0, chk_addr_q - start_q} + CW'(1);
              chk_vld_d           = 1'b0;
              state_d             = ST_WRITE;
            end else if (chk_addr_q == end_q) begin
              res_d.status = scra_pkg::STATUS_BAD_FREE;
              state_d      = ST_DONE;
            end
          end else begin
            run_d = run_n;
            if (run_n >= need_q) begin
              waddr_d          = chk_addr_q - len_q;
              wend_d           = chk_addr_q;
              res_d.status     = scra_pkg::STATUS_OK;
              res_d.first_slot = chk_addr_q - len_q;
              chk_vld_d        = 1'b0;
              state_d          = ST_WRITE;
            end else if (chk_addr_q == end_q) begin
              if (!pass_q) begin
                pass_d  = 1'b1;
                addr_d  = '0;
                end_d   = cursor_q | scra_pkg::RowMask;
                run_d   = '0;
                issue_d = 1'b1;
              end else begin
                res_d.status = scra_pkg::STATUS_NO_SPACE;
                state_d      = ST_DONE;
              end
            end
          end
        end
      end

      ST_WRITE: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = waddr_q;
        if (cmd_q == scra_pkg::CMD_FREE) begin
          mem_req_o.wdata = scra_pkg::SLOT_FREE;
        end else if (waddr_q == wend_q) begin
          mem_req_o.wdata = scra_pkg::SLOT_GUARD;
        end else begin
          mem_req_o.wdata = scra_pkg::SLOT_MAPPED;
        end
        waddr_d = waddr_q + SW'(1);
        if (waddr_q == wend_q) begin
          if (cmd_q == scra_pkg::CMD_ALLOC) begin
            cursor_d = wend_q;
          end
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      waddr_q   <= '0;
      cursor_q  <= '0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      waddr_q   <= waddr_d;
      cursor_q  <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pass_q     <= pass_d;
    addr_q     <= addr_d;
    chk_addr_q <= chk_addr_d;
    end_q      <= end_d;
    wend_q     <= wend_d;
    len_q      <= len_d;
    start_q    <= start_d;
    need_q     <= need_d;
    run_q      <= run_d;
    res_q      <= res_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    res_o       = res_q;
    res_o.valid = (state_q == ST_DONE);
  end

endmodule

@@ src/contiguous_slot_run_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_unit
// next-fit allocator of guarded contiguous runs over 4096 page slots
// ----------------------------------------------------------------------------
// one request enters on the s_axis channel: tuser carries the command
// (allocate or free), tdata the run length and the start slot. one result
// leaves on the m_axis channel per request: status, first slot of an
// allocated run and the number of slots a free cleared.
// an allocate scans the slot memory one slot per cycle after the cursor, then
// from slot 0 through the cursor's row, and writes the run back one slot per
// cycle; a free scans from its start slot to the guard and clears that span.
// one request is in work at a time; s_axis_tready is high while idle.
// after reset the block sweeps all 4096 slots of the slot memory to free
// before it takes the first request.
// the result sits in an output register; when the receiver stalls a new
// request is still taken and worked on, and its result waits for the
// register to drain.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // run_length[11:0], start_slot[23:12]
  input  logic        s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // status[1:0], first_slot[13:2], slots_cleared[26:14]
);

  scra_pkg::mem_req_t mem_req;
  scra_pkg::result_t  res;
  logic [1:0]         mem_rdata;
  logic               res_take;
  logic               out_vld_q;
  logic [26:0]        out_data_q;

  scra_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  scra_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .run_length_i (s_axis_tdata[11:0]),
    .start_slot_i (s_axis_tdata[23:12]),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  assign res_take = res.valid && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= {res.slots_cleared, res.first_slot, res.status};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_data_q};

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the next-fit contiguous slot run allocator
// ----------------------------------------------------------------------------
// requests go in on s_axis and results come out on m_axis. A predictor keeps
// its own copy of the slot map and the next-fit cursor, and it works out the
// result of every accepted request. Each result is checked field by field
// against the oldest pending expected result.
// The directed part comes first. It covers the field extremes, a zero
// length, a run too large to fit, a cursor on the last slot, runs that span
// rows, a free that walks over free slots, and a free with no guard. Random
// traffic follows: allocate and free sequences with noise mixed in, run
// under several idle and stall patterns. One long receiver hold-off fills
// the block so that its input stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scra_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] first_slot;
    logic [CntW-1:0]  slots_cleared;
  } run_result_t;

  typedef struct packed {
    cmd_e             op;
    logic [SlotW-1:0] run_length;
    logic [SlotW-1:0] start_slot;
    logic             typed;
    run_result_t      want;
  } step_row_t;

  localparam int NumRows        = 18;
  localparam int RandomRequests = 120;
  localparam int NumPhases      = 4;
  localparam int HoldOffCycles  = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  contiguous_slot_run_allocator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  slot_e            slot_map [TotalSlots];
  logic [SlotW-1:0] fit_cursor;
  run_result_t      pending_results [$];
  logic [SlotW-1:0] live_runs [$];
  step_row_t        directed_rows [NumRows];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off_req;
  bit  hold_off_taken;
  int  hold_left;
  int  failures;
  int  requests_sent;
  int  runs_placed;
  int  runs_refused;
  int  frees_done;
  int  frees_rejected;
  int  full_stall_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  function automatic bit scan_free_run(input int from, input int to_excl, input int need,
                                       output int guard);
    int run;
    run   = 0;
    guard = 0;
    for (int s = from; s < to_excl && s < int'(TotalSlots); s++) begin
      if (slot_map[s] == SLOT_FREE) begin
        run++;
      end else begin
        run = 0;
      end
      if (run >= need) begin
        guard = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic run_result_t predict_request(input cmd_e op,
                                                  input logic [SlotW-1:0] run_length,
                                                  input logic [SlotW-1:0] start_slot);
    run_result_t r;
    int          guard;
    int          row_end;
    int          len;
    int          g;
    bit          found;
    r     = '0;
    len   = int'(run_length);
    found = 1'b0;
    if (op == CMD_ALLOC) begin
      r.status = STATUS_NO_SPACE;
      if (len != 0) begin
        found = scan_free_run(int'(fit_cursor) + 1, int'(TotalSlots), len + 1, guard);
        if (!found) begin
          // wrap: from slot 0 through the end of the cursor's row
          row_end = (int'(fit_cursor) / int'(RowSlots) + 1) * int'(RowSlots);
          if (row_end > int'(TotalSlots)) begin
            row_end = int'(TotalSlots);
          end
          found = scan_free_run(0, row_end, len + 1, guard);
        end
      end
      if (found) begin
        for (int s = guard - len; s < guard; s++) begin
          slot_map[s] = SLOT_MAPPED;
        end
        slot_map[guard] = SLOT_GUARD;
        fit_cursor      = SlotW'(guard);
        r.status        = STATUS_OK;
        r.first_slot    = SlotW'(guard - len);
        live_runs.push_back(r.first_slot);
        runs_placed++;
      end else begin
        runs_refused++;
      end
    end else begin
      r.status = STATUS_BAD_FREE;
      g = int'(start_slot);
      while (g < int'(TotalSlots) && slot_map[g] != SLOT_GUARD) begin
        g++;
      end
      if (g < int'(TotalSlots)) begin
        for (int s = int'(start_slot); s <= g; s++) begin
          slot_map[s] = SLOT_FREE;
        end
        r.status        = STATUS_OK;
        r.slots_cleared = CntW'(g - int'(start_slot) + 1);
        frees_done++;
      end else begin
        frees_rejected++;
      end
    end
    return r;
  endfunction

  task automatic offer_request(input cmd_e op, input logic [SlotW-1:0] run_length,
                               input logic [SlotW-1:0] start_slot, input logic typed,
                               input run_result_t want);
    run_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {start_slot, run_length};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_request(op, run_length, start_slot);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic note_failure(input string what, input run_result_t want,
                              input logic [31:0] got);
    failures++;
    if (failures <= 10) begin
      $write("%0t %s: expected status %0d first %0d cleared %0d",
             $realtime, what, want.status, want.first_slot, want.slots_cleared);
      $display(", got status %0d first %0d cleared %0d",
               got[1:0], got[13:2], got[26:14]);
    end
  endtask

  // result check and back-pressure count
  always @(posedge clk_i) begin : result_check
    run_result_t want;
    if (m_axis_tvalid && !m_axis_tready && s_axis_tvalid && !s_axis_tready) begin
      full_stall_cycles++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_failure("result with nothing pending", '0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[13:2] !== want.first_slot ||
            m_axis_tdata[26:14] !== want.slots_cleared) begin
          note_failure("result mismatch", want, m_axis_tdata);
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready  = 1'b0;
    hold_off_taken = 1'b0;
    hold_left      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        hold_left      = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout with %0d results pending", pending_results.size());
    $display("contiguous_slot_run_allocator_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int               pick;
    int               idx;
    cmd_e             op;
    logic [SlotW-1:0] len;
    logic [SlotW-1:0] start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ALLOC;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req  = 1'b0;
    failures      = 0;
    requests_sent = 0;
    runs_placed   = 0;
    runs_refused  = 0;
    frees_done    = 0;
    frees_rejected = 0;
    full_stall_cycles = 0;
    fit_cursor    = '0;
    foreach (slot_map[i]) slot_map[i] = SLOT_FREE;

    directed_rows = '{
      '{CMD_ALLOC, 12'd1,    12'hfff, 1'b1, '{STATUS_OK,       12'd1, 13'd0}},
      '{CMD_FREE,  12'hfff,  12'd1,   1'b1, '{STATUS_OK,       12'd0, 13'd2}},
      '{CMD_ALLOC, 12'd0,    12'h555, 1'b1, '{STATUS_NO_SPACE, 12'd0, 13'd0}},
      '{CMD_ALLOC, 12'd4095, 12'd0,   1'b1, '{STATUS_NO_SPACE, 12'd0, 13'd0}},
      '{CMD_FREE,  12'd0,    12'd4095, 1'b1, '{STATUS_BAD_FREE, 12'd0, 13'd0}},
      '{CMD_FREE,  12'haaa,  12'd0,   1'b1, '{STATUS_BAD_FREE, 12'd0, 13'd0}},
      '{CMD_ALLOC, 12'd2048, 12'hfff, 1'b0, '0},
      '{CMD_ALLOC, 12'd2048, 12'd0,   1'b0, '0},
      '{CMD_ALLOC, 12'd1000, 12'h555, 1'b0, '0},
      '{CMD_ALLOC, 12'd1043, 12'haaa, 1'b0, '0},
      '{CMD_ALLOC, 12'd1042, 12'd0,   1'b0, '0},
      '{CMD_FREE,  12'h555,  12'd4095, 1'b1, '{STATUS_OK,      12'd0, 13'd1}},
      '{CMD_ALLOC, 12'd2,    12'hfff, 1'b0, '0},
      '{CMD_FREE,  12'hfff,  12'd3,   1'b0, '0},
      '{CMD_FREE,  12'd0,    12'd2000, 1'b0, '0},
      '{CMD_FREE,  12'haaa,  12'd3053, 1'b1, '{STATUS_BAD_FREE, 12'd0, 13'd0}},
      '{CMD_ALLOC, 12'd5,    12'h555, 1'b0, '0},
      '{CMD_FREE,  12'd7,    12'd0,   1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].op, directed_rows[i].run_length,
                    directed_rows[i].start_slot, directed_rows[i].typed,
                    directed_rows[i].want);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_off_req   = 1'b1;
        end
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < RandomRequests / NumPhases; n++) begin
        pick  = $urandom_range(99);
        len   = SlotW'($urandom_range(4095));
        start = SlotW'($urandom_range(4095));
        op    = CMD_ALLOC;
        if (pick < 35) begin
          len = SlotW'($urandom_range(64, 1));
        end else if (pick < 45) begin
          len = SlotW'($urandom_range(400, 65));
        end else if (pick < 80 && live_runs.size() != 0) begin
          op    = CMD_FREE;
          idx   = $urandom_range(live_runs.size() - 1);
          start = live_runs[idx];
          live_runs.delete(idx);
        end else if (pick < 80) begin
          len = SlotW'($urandom_range(64, 1));
        end else if (pick < 85) begin
          // any length, the huge ones included
        end else if (pick < 90) begin
          len = ($urandom_range(1) == 0) ? '0 : SlotW'($urandom_range(400, 65));
        end else begin
          op = CMD_FREE;
        end
        offer_request(op, len, start, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d requests: %0d runs placed, %0d refused for lack of space",
             requests_sent, runs_placed, runs_refused);
    $display("%0d frees done, %0d rejected; input held off %0d cycles behind a full output",
             frees_done, frees_rejected, full_stall_cycles);
    if (failures == 0) begin
      $display("contiguous_slot_run_allocator_unit regression: pass");
    end else begin
      $display("contiguous_slot_run_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
